// ===== design/sequential_record_list_unit_assert.svh =====
// Assertion macros for the record list unit.
`ifndef SEQUENTIAL_RECORD_LIST_UNIT_ASSERT_SVH
`define SEQUENTIAL_RECORD_LIST_UNIT_ASSERT_SVH

// same-cycle implication
`define SRLU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srlu assertion failed");

// next-cycle implication
`define SRLU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srlu assertion failed");

`endif

// ===== design/srlu_pkg.sv =====
`default_nettype none

package srlu_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 7;
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [3:0] {
    CMD_INS_BACK   = 4'd0,
    CMD_INS_FRONT  = 4'd1,
    CMD_INS_SORTED = 4'd2,
    CMD_READ_POS   = 4'd3,
    CMD_FIND_KEY   = 4'd4,
    CMD_RM_FRONT   = 4'd5,
    CMD_RM_BACK    = 4'd6,
    CMD_RM_KEY     = 4'd7,
    CMD_RM_SWAP    = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MODE_KEEP,
    MODE_INS,
    MODE_DEL,
    MODE_SWAP
  } mode_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic signed [31:0] key;
    logic [31:0]        pay;
  } rec_t;

  // compare phase control, broadcast to all cells
  typedef struct packed {
    logic               en;
    cmd_e               cmd;
    logic signed [31:0] key;
    logic [CMP_W-1:0]   pos_m1;
    logic [CNT_W-1:0]   count;
  } flag_ctl_t;

  // update phase control, broadcast to all cells
  typedef struct packed {
    mode_e mode;
    rec_t  new_rec;
    rec_t  last_rec;
  } op_ctl_t;

endpackage

`default_nettype wire

// ===== design/sequential_record_list_unit.sv =====
// chan | handshake                 | beat
// in   | in_valid_i / in_ready_o   | cmd_i, key_i, payload_i, position_i
// out  | out_valid_o / out_ready_i | status_o, found_key_o, found_payload_o, entry_count_o
// Each command has a compare cycle, then an update cycle in the cell chain.
// The update cycle waits while the output register holds an untaken beat.
// A new command is taken while the previous result still waits.
// Reset clears count and control; record contents are undefined until written.
`default_nettype none

module sequential_record_list_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [3:0]                  cmd_i,
  input  logic signed [31:0]          key_i,
  input  logic [31:0]                 payload_i,
  input  logic [srlu_pkg::POS_W-1:0]  position_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  status_o,
  output logic signed [31:0]          found_key_o,
  output logic [31:0]                 found_payload_o,
  output logic [srlu_pkg::POS_W-1:0]  entry_count_o
);
  import srlu_pkg::*;

  state_e state_q, state_d;
  cmd_e cmd_q;
  rec_t new_rec_q, last_rec_q, last_rec_all, sel_rec_all;
  logic [CNT_W-1:0] count_q, count_d;
  logic out_valid_q, out_valid_d;
  status_e status_q, status_d;
  rec_t res_rec_q, res_rec_d;

  logic in_acc, exec_go;
  flag_ctl_t flag_ctl;
  op_ctl_t op_ctl;
  mode_e mode;

  rec_t rec_arr  [CAPACITY];
  rec_t sel_arr  [CAPACITY];
  rec_t last_arr [CAPACITY];
  logic [CAPACITY:0] hit_chain;
  logic [CAPACITY:0] ge_chain;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign exec_go    = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  assign flag_ctl.en     = in_acc;
  assign flag_ctl.cmd    = cmd_e'(cmd_i);
  assign flag_ctl.key    = key_i;
  assign flag_ctl.pos_m1 = CMP_W'(position_i) - CMP_W'(1);
  assign flag_ctl.count  = count_q;

  assign op_ctl.mode     = mode;
  assign op_ctl.new_rec  = new_rec_q;
  assign op_ctl.last_rec = last_rec_q;

  assign hit_chain[0] = 1'b0;
  assign ge_chain[0]  = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    rec_t left_rec, right_rec;
    if (g == 0) begin : g_first
      assign left_rec = '0;
    end else begin : g_mid_l
      assign left_rec = rec_arr[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_rec = '0;
    end else begin : g_mid_r
      assign right_rec = rec_arr[g+1];
    end
    srlu_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (IDX_W'(g)),
      .flag_ctl_i (flag_ctl),
      .op_ctl_i   (op_ctl),
      .left_rec_i (left_rec),
      .right_rec_i(right_rec),
      .hit_prev_i (hit_chain[g]),
      .ge_prev_i  (ge_chain[g]),
      .rec_o      (rec_arr[g]),
      .hit_o      (hit_chain[g+1]),
      .ge_o       (ge_chain[g+1]),
      .sel_rec_o  (sel_arr[g]),
      .last_rec_o (last_arr[g])
    );
  end

  always_comb begin
    sel_rec_all  = '0;
    last_rec_all = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_rec_all  = sel_rec_all | sel_arr[i];
      last_rec_all = last_rec_all | last_arr[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      new_rec_q.key <= key_i;
      new_rec_q.pay <= payload_i;
      last_rec_q    <= last_rec_all;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= CMD_INS_BACK;
    end else if (in_acc) begin
      cmd_q <= cmd_e'(cmd_i);
    end
  end

  // update phase decode
  always_comb begin
    mode      = MODE_KEEP;
    status_d  = ST_OK;
    res_rec_d = '0;
    count_d   = count_q;
    unique case (cmd_q) inside
      CMD_INS_BACK, CMD_INS_FRONT, CMD_INS_SORTED: begin
        if (count_q == CNT_W'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          mode    = MODE_INS;
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_READ_POS, CMD_FIND_KEY: begin
        if (hit_chain[CAPACITY]) begin
          res_rec_d = sel_rec_all;
        end else begin
          status_d = (cmd_q == CMD_READ_POS) ? ST_BAD_POS : ST_NOT_FOUND;
        end
      end
      CMD_RM_FRONT, CMD_RM_BACK: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          mode    = (cmd_q == CMD_RM_FRONT) ? MODE_DEL : MODE_KEEP;
          count_d = count_q - CNT_W'(1);
        end
      end
      CMD_RM_KEY, CMD_RM_SWAP: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (!hit_chain[CAPACITY]) begin
          status_d = ST_NOT_FOUND;
        end else begin
          mode    = (cmd_q == CMD_RM_KEY) ? MODE_DEL : MODE_SWAP;
          count_d = count_q - CNT_W'(1);
        end
      end
      default: ;
    endcase
    if (!exec_go) begin
      mode    = MODE_KEEP;
      count_d = count_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      status_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      if (exec_go) begin
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      res_rec_q <= res_rec_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign found_key_o     = res_rec_q.key;
  assign found_payload_o = res_rec_q.pay;
  assign entry_count_o   = POS_W'(count_q);

`include "sequential_record_list_unit_assert.svh"

  `SRLU_ASSERT_NOW(a_count_in_range, 1'b1, count_q <= CNT_W'(CAPACITY))
  `SRLU_ASSERT_NXT(a_accept_starts_exec, in_acc, state_q == S_EXEC && !in_ready_o)
  `SRLU_ASSERT_NXT(a_exec_gives_beat, exec_go, out_valid_o)
  `SRLU_ASSERT_NXT(a_insert_grows, exec_go && mode == MODE_INS,
                   count_q == $past(count_q) + CNT_W'(1))
  `SRLU_ASSERT_NOW(a_full_means_capacity, out_valid_o && status_q == ST_FULL,
                   count_q == CNT_W'(CAPACITY))

endmodule

`default_nettype wire

// ===== design/srlu_cell.sv =====
`default_nettype none

module srlu_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [srlu_pkg::IDX_W-1:0] idx_i,
  input  srlu_pkg::flag_ctl_t       flag_ctl_i,
  input  srlu_pkg::op_ctl_t         op_ctl_i,
  input  srlu_pkg::rec_t            left_rec_i,
  input  srlu_pkg::rec_t            right_rec_i,
  input  logic                      hit_prev_i,
  input  logic                      ge_prev_i,
  output srlu_pkg::rec_t            rec_o,
  output logic                      hit_o,
  output logic                      ge_o,
  output srlu_pkg::rec_t            sel_rec_o,
  output srlu_pkg::rec_t            last_rec_o
);
  import srlu_pkg::*;

  rec_t rec_q, rec_d;
  logic hit_q, hit_d;
  logic ge_q, ge_d;
  logic occupied, is_last, first_hit, first_ge;

  assign occupied = CNT_W'(idx_i) < flag_ctl_i.count;
  assign is_last  = occupied && (CNT_W'(idx_i) == flag_ctl_i.count - CNT_W'(1));

  always_comb begin
    hit_d = 1'b0;
    ge_d  = 1'b0;
    unique case (flag_ctl_i.cmd) inside
      CMD_READ_POS: hit_d = occupied && (CMP_W'(idx_i) == flag_ctl_i.pos_m1);
      CMD_FIND_KEY, CMD_RM_KEY, CMD_RM_SWAP: hit_d = occupied && (rec_q.key == flag_ctl_i.key);
      CMD_RM_FRONT: hit_d = occupied && (idx_i == '0);
      CMD_INS_BACK: ge_d = !occupied;
      CMD_INS_FRONT: ge_d = 1'b1;
      CMD_INS_SORTED: ge_d = !occupied || !($signed(rec_q.key) < $signed(flag_ctl_i.key));
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      ge_q  <= 1'b0;
    end else if (flag_ctl_i.en) begin
      hit_q <= hit_d;
      ge_q  <= ge_d;
    end
  end

  assign first_hit = hit_q && !hit_prev_i;
  assign first_ge  = ge_q && !ge_prev_i;

  always_comb begin
    rec_d = rec_q;
    case (op_ctl_i.mode)
      MODE_INS: begin
        if (first_ge) begin
          rec_d = op_ctl_i.new_rec;
        end else if (ge_prev_i) begin
          rec_d = left_rec_i;
        end
      end
      MODE_DEL: begin
        if (hit_prev_i || hit_q) begin
          rec_d = right_rec_i;
        end
      end
      MODE_SWAP: begin
        if (first_hit) begin
          rec_d = op_ctl_i.last_rec;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o      = rec_q;
  assign hit_o      = hit_prev_i || hit_q;
  assign ge_o       = ge_prev_i || ge_q;
  assign sel_rec_o  = first_hit ? rec_q : '0;
  assign last_rec_o = is_last ? rec_q : '0;

endmodule

`default_nettype wire
